FILE: rtl/jdm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jdm_pkg
// shared field widths, register codes, reset values and helpers of the
// joystick to drive duty mixer
// ----------------------------------------------------------------------------
package jdm_pkg;

  localparam int unsigned STICK_W    = 10;
  localparam int unsigned DUTY_W     = 8;
  localparam int unsigned CENTER_W   = 10;
  localparam int unsigned TRIM_W     = 8;
  localparam int unsigned DEAD_W     = 7;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;

  // percent error, sum of errors, scaled numerator
  localparam int unsigned ERR_W = 17;
  localparam int unsigned SUM_W = 18;
  localparam int unsigned MIX_W = 24;
  localparam int unsigned MIXQ_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_X_CENTER   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_CENTER   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_TRIM = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND   = 2'd3;

  localparam logic [CENTER_W-1:0] X_CENTER_RST = 10'd161;
  localparam logic [CENTER_W-1:0] Y_CENTER_RST = 10'd166;
  localparam logic [TRIM_W-1:0]   TRIM_RST     = 8'd243;
  localparam logic [DEAD_W-1:0]   DEAD_RST     = 7'd5;

  localparam logic [ERR_W-1:0] BOOST_NUM = 17'd269;

  typedef enum logic [1:0] {
    CASE_STOP,
    CASE_STRAIGHT,
    CASE_PIVOT,
    CASE_MIXED
  } drive_case_e;

  typedef struct packed {
    logic x_pos;
    logic y_pos;
    logic a_sel;
  } div1_side_t;

  typedef struct packed {
    drive_case_e       mode;
    logic              x_pos;
    logic              y_pos;
    logic [DUTY_W-1:0] lsat;
    logic [DUTY_W-1:0] r1;
    logic              lrev;
    logic              rrev;
  } div2_side_t;

  function automatic logic [DUTY_W-1:0] sat_u8(input logic [24:0] v);
    return (v > 25'd255) ? 8'hFF : v[DUTY_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/jdm_stick_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jdm_stick_if
// joystick sample channel, one beat per sample
// ----------------------------------------------------------------------------
interface jdm_stick_if import jdm_pkg::*; ();

  logic               valid;
  logic               ready;
  logic [STICK_W-1:0] stick_x;
  logic [STICK_W-1:0] stick_y;

  modport source (output valid, output stick_x, output stick_y, input ready);
  modport sink   (input valid, input stick_x, input stick_y, output ready);

endinterface

`default_nettype wire

FILE: rtl/jdm_duty_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jdm_duty_if
// motor duty channel, one beat per result
// ----------------------------------------------------------------------------
interface jdm_duty_if import jdm_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] left_duty;
  logic [DUTY_W-1:0] right_duty;
  logic              left_reverse;
  logic              right_reverse;

  modport source (output valid, output left_duty, output right_duty,
                  output left_reverse, output right_reverse, input ready);
  modport sink   (input valid, input left_duty, input right_duty,
                  input left_reverse, input right_reverse, output ready);

endinterface

`default_nettype wire

FILE: rtl/jdm_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jdm_div
// pipelined restoring divider, STEP_W quotient bits per stage, lanes share
// one handshake and carry a sideband word alongside
// ----------------------------------------------------------------------------
module jdm_div #(
  parameter int unsigned LANES  = 1,
  parameter int unsigned NUM_W  = 17,
  parameter int unsigned DEN_W  = 10,
  parameter int unsigned Q_W    = 17,
  parameter int unsigned SIDE_W = 1,
  parameter int unsigned STEP_W = 3
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [NUM_W-1:0]  num_i [LANES],
  input  wire logic [DEN_W-1:0]  den_i [LANES],
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [Q_W-1:0]         quo_o [LANES],
  output logic [SIDE_W-1:0]      side_o
);

  localparam int unsigned STAGES = (Q_W + STEP_W - 1) / STEP_W;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [Q_W-1:0]   low;
  } acc_t;

  function automatic acc_t div_steps(input acc_t a, input logic [DEN_W-1:0] den,
                                     input int unsigned first);
    acc_t           r;
    logic [DEN_W:0] top;
    r = a;
    for (int unsigned j = 0; j < STEP_W; j++) begin
      if (first + j < Q_W) begin
        top = {r.rem, r.low[Q_W-1]};
        if (top >= {1'b0, den}) begin
          r.rem = DEN_W'(top - {1'b0, den});
          r.low = {r.low[Q_W-2:0], 1'b1};
        end else begin
          r.rem = top[DEN_W-1:0];
          r.low = {r.low[Q_W-2:0], 1'b0};
        end
      end
    end
    return r;
  endfunction

  logic              v_q    [STAGES];
  acc_t              acc_q  [STAGES][LANES];
  logic [DEN_W-1:0]  den_q  [STAGES][LANES];
  logic [SIDE_W-1:0] side_q [STAGES];
  logic              rdy    [STAGES+1];

  assign rdy[STAGES] = out_ready_i;
  assign in_ready_o  = rdy[0];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic              v_in;
    logic [SIDE_W-1:0] side_in;
    acc_t              acc_in [LANES];
    acc_t              acc_nx [LANES];
    logic [DEN_W-1:0]  den_in [LANES];

    assign rdy[s] = !v_q[s] || rdy[s+1];

    if (s == 0) begin : g_head
      assign v_in    = in_valid_i;
      assign side_in = side_i;
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign acc_in[l] = '{rem: DEN_W'(num_i[l] >> Q_W), low: num_i[l][Q_W-1:0]};
        assign den_in[l] = den_i[l];
      end
    end else begin : g_body
      assign v_in    = v_q[s-1];
      assign side_in = side_q[s-1];
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign acc_in[l] = acc_q[s-1][l];
        assign den_in[l] = den_q[s-1][l];
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_calc
      assign acc_nx[l] = div_steps(acc_in[l], den_in[l], s * STEP_W);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (rdy[s]) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s]) begin
        side_q[s] <= side_in;
        for (int unsigned l = 0; l < LANES; l++) begin
          acc_q[s][l] <= acc_nx[l];
          den_q[s][l] <= den_in[l];
        end
      end
    end
  end

  assign out_valid_o = v_q[STAGES-1];
  assign side_o      = side_q[STAGES-1];

  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign quo_o[l] = acc_q[STAGES-1][l].low;
  end

endmodule

`default_nettype wire

FILE: rtl/joystick_to_drive_duty_mixer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// joystick_to_drive_duty_mixer
// turns a joystick sample into two motor duties and direction bits
// ----------------------------------------------------------------------------
// order: stage a, error divider, stages b to d, mix divider, stage e
// throughput: one sample per cycle while duty_o.ready is high, set by the two
// pipelined dividers (percent error, mix ratio), DIV_STEPS quotient bits a stage
// reset: pipeline valid bits clear, config registers take their reset values
// ----------------------------------------------------------------------------
module joystick_to_drive_duty_mixer import jdm_pkg::*; #(
  parameter int unsigned DIV_STEPS = 3
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  jdm_stick_if.sink                  stick_i,
  jdm_duty_if.source                 duty_o
);

  // configuration
  logic [CENTER_W-1:0] x_center_q;
  logic [CENTER_W-1:0] y_center_q;
  logic [TRIM_W-1:0]   trim_q;
  logic [DEAD_W-1:0]   dead_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_center_q <= X_CENTER_RST;
      y_center_q <= Y_CENTER_RST;
      trim_q     <= TRIM_RST;
      dead_q     <= DEAD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_X_CENTER:   x_center_q <= cfg_wdata_i[CENTER_W-1:0];
        REG_Y_CENTER:   y_center_q <= cfg_wdata_i[CENTER_W-1:0];
        REG_RIGHT_TRIM: trim_q     <= cfg_wdata_i[TRIM_W-1:0];
        REG_DEADBAND:   dead_q     <= cfg_wdata_i[DEAD_W-1:0];
        default: ;
      endcase
    end
  end

  // stage ready chain
  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e;
  logic d1_in_ready, d1_out_valid;
  logic d2_in_ready, d2_out_valid;

  // stage a: deviation times 100 and divisor
  logic                a_v_q;
  logic [ERR_W-1:0]    a_numx_q, a_numy_q;
  logic [CENTER_W-1:0] a_denx_q, a_deny_q;
  div1_side_t          a_side_q;
  logic [STICK_W-1:0]  diffx, diffy;

  assign rdy_a         = !a_v_q || d1_in_ready;
  assign stick_i.ready = rdy_a;

  always_comb begin
    diffx = (stick_i.stick_x >= x_center_q) ? stick_i.stick_x - x_center_q
                                            : x_center_q - stick_i.stick_x;
    diffy = (stick_i.stick_y >= y_center_q) ? stick_i.stick_y - y_center_q
                                            : y_center_q - stick_i.stick_y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (rdy_a) begin
      a_v_q <= stick_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a) begin
      a_numx_q       <= ERR_W'(ERR_W'(diffx) * ERR_W'(100));
      a_numy_q       <= ERR_W'(ERR_W'(diffy) * ERR_W'(100));
      a_denx_q       <= (x_center_q == '0) ? CENTER_W'(1) : x_center_q;
      a_deny_q       <= (y_center_q == '0) ? CENTER_W'(1) : y_center_q;
      a_side_q.x_pos <= stick_i.stick_x > x_center_q;
      a_side_q.y_pos <= stick_i.stick_y > y_center_q;
      a_side_q.a_sel <= {stick_i.stick_y, 1'b0} <= {1'b0, y_center_q};
    end
  end

  // percent error divider, x and y lanes
  logic [ERR_W-1:0]    d1_num [2];
  logic [CENTER_W-1:0] d1_den [2];
  logic [ERR_W-1:0]    d1_quo [2];
  div1_side_t          d1_side;

  assign d1_num[0] = a_numx_q;
  assign d1_num[1] = a_numy_q;
  assign d1_den[0] = a_denx_q;
  assign d1_den[1] = a_deny_q;

  jdm_div #(
    .LANES  (2),
    .NUM_W  (ERR_W),
    .DEN_W  (CENTER_W),
    .Q_W    (ERR_W),
    .SIDE_W ($bits(div1_side_t)),
    .STEP_W (DIV_STEPS)
  ) u_err_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (a_v_q),
    .in_ready_o  (d1_in_ready),
    .num_i       (d1_num),
    .den_i       (d1_den),
    .side_i      (a_side_q),
    .out_valid_o (d1_out_valid),
    .out_ready_i (rdy_b),
    .quo_o       (d1_quo),
    .side_o      (d1_side)
  );

  // stage b: region select
  logic             b_v_q;
  drive_case_e      b_mode_q;
  logic [ERR_W-1:0] b_a_q, b_esel_q;
  logic [SUM_W-1:0] b_sum_q;
  logic             b_xpos_q, b_ypos_q, b_lrev_q, b_rrev_q;

  drive_case_e      mode;
  logic [ERR_W-1:0] ex, ey, dz, a_val, esel;
  logic             lrev, rrev;

  assign rdy_b = !b_v_q || rdy_c;

  always_comb begin
    ex    = d1_quo[0];
    ey    = d1_quo[1];
    dz    = ERR_W'(dead_q);
    a_val = d1_side.a_sel ? ey : ex;
    if (ey > dz && ex < dz) begin
      mode = CASE_STRAIGHT;
    end else if (ex > dz && ey < dz) begin
      mode = CASE_PIVOT;
    end else if (ex > dz && ey > dz) begin
      mode = CASE_MIXED;
    end else begin
      mode = CASE_STOP;
    end
  end

  always_comb begin
    case (mode)
      CASE_STRAIGHT: begin
        esel = ey;
        lrev = !d1_side.y_pos;
        rrev = !d1_side.y_pos;
      end
      CASE_PIVOT: begin
        esel = ex;
        lrev = d1_side.x_pos;
        rrev = !d1_side.x_pos;
      end
      CASE_MIXED: begin
        esel = a_val;
        lrev = !d1_side.y_pos;
        rrev = !d1_side.y_pos;
      end
      default: begin
        esel = ex;
        lrev = 1'b0;
        rrev = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (rdy_b) begin
      b_v_q <= d1_out_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_b) begin
      b_mode_q <= mode;
      b_a_q    <= a_val;
      b_esel_q <= esel;
      b_sum_q  <= SUM_W'(ex) + SUM_W'(ey);
      b_xpos_q <= d1_side.x_pos;
      b_ypos_q <= d1_side.y_pos;
      b_lrev_q <= lrev;
      b_rrev_q <= rrev;
    end
  end

  // stage c: a times 100, selected error times trim
  logic              c_v_q;
  drive_case_e       c_mode_q;
  logic [MIX_W-1:0]  c_a100_q;
  logic [24:0]       c_prod_q;
  logic [DUTY_W-1:0] c_lsat_q;
  logic [SUM_W-1:0]  c_sum_q;
  logic              c_xpos_q, c_ypos_q, c_lrev_q, c_rrev_q;

  assign rdy_c = !c_v_q || rdy_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
    end else if (rdy_c) begin
      c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_c) begin
      c_mode_q <= b_mode_q;
      c_a100_q <= MIX_W'(MIX_W'(b_a_q) * MIX_W'(100));
      c_prod_q <= 25'(b_esel_q) * 25'(trim_q);
      c_lsat_q <= sat_u8(25'(b_esel_q));
      c_sum_q  <= b_sum_q;
      c_xpos_q <= b_xpos_q;
      c_ypos_q <= b_ypos_q;
      c_lrev_q <= b_lrev_q;
      c_rrev_q <= b_rrev_q;
    end
  end

  // stage d: mix numerator and trimmed duty
  logic             d_v_q;
  logic [MIX_W-1:0] d_num_q;
  logic [SUM_W-1:0] d_sum_q;
  div2_side_t       d_side_q;
  logic [31:0]      a100_trim;

  assign rdy_d     = !d_v_q || d2_in_ready;
  assign a100_trim = 32'(c_a100_q) * 32'(trim_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_v_q <= 1'b0;
    end else if (rdy_d) begin
      d_v_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_d) begin
      d_num_q        <= c_xpos_q ? a100_trim[31:8] : c_a100_q;
      d_sum_q        <= c_sum_q;
      d_side_q.mode  <= c_mode_q;
      d_side_q.x_pos <= c_xpos_q;
      d_side_q.y_pos <= c_ypos_q;
      d_side_q.lsat  <= c_lsat_q;
      d_side_q.r1    <= sat_u8(25'(c_prod_q[24:8]));
      d_side_q.lrev  <= c_lrev_q;
      d_side_q.rrev  <= c_rrev_q;
    end
  end

  // mix ratio divider
  logic [MIX_W-1:0]  d2_num [1];
  logic [SUM_W-1:0]  d2_den [1];
  logic [MIXQ_W-1:0] d2_quo [1];
  div2_side_t        d2_side;

  assign d2_num[0] = d_num_q;
  assign d2_den[0] = d_sum_q;

  jdm_div #(
    .LANES  (1),
    .NUM_W  (MIX_W),
    .DEN_W  (SUM_W),
    .Q_W    (MIXQ_W),
    .SIDE_W ($bits(div2_side_t)),
    .STEP_W (DIV_STEPS)
  ) u_mix_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (d_v_q),
    .in_ready_o  (d2_in_ready),
    .num_i       (d2_num),
    .den_i       (d2_den),
    .side_i      (d_side_q),
    .out_valid_o (d2_out_valid),
    .out_ready_i (rdy_e),
    .quo_o       (d2_quo),
    .side_o      (d2_side)
  );

  // stage e: backward boost and output register
  logic              e_v_q;
  logic [DUTY_W-1:0] e_left_q, e_right_q;
  logic              e_lrev_q, e_rrev_q;
  logic [DUTY_W-1:0] left_d, right_d, boost, q8;
  logic [ERR_W-1:0]  boost_prod;

  assign rdy_e      = !e_v_q || duty_o.ready;
  assign boost_prod = ERR_W'(d2_side.r1) * BOOST_NUM;
  assign boost      = sat_u8(25'(boost_prod[ERR_W-1:8]));
  assign q8         = DUTY_W'(d2_quo[0]);

  always_comb begin
    case (d2_side.mode)
      CASE_STRAIGHT: begin
        left_d  = d2_side.lsat;
        right_d = d2_side.y_pos ? d2_side.r1 : boost;
      end
      CASE_PIVOT: begin
        left_d  = d2_side.lsat;
        right_d = d2_side.r1;
      end
      CASE_MIXED: begin
        left_d  = d2_side.x_pos ? d2_side.lsat : q8;
        right_d = d2_side.x_pos ? q8 : d2_side.r1;
      end
      default: begin
        left_d  = '0;
        right_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_v_q <= 1'b0;
    end else if (rdy_e) begin
      e_v_q <= d2_out_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_e) begin
      e_left_q  <= left_d;
      e_right_q <= right_d;
      e_lrev_q  <= d2_side.lrev;
      e_rrev_q  <= d2_side.rrev;
    end
  end

  assign duty_o.valid         = e_v_q;
  assign duty_o.left_duty     = e_left_q;
  assign duty_o.right_duty    = e_right_q;
  assign duty_o.left_reverse  = e_lrev_q;
  assign duty_o.right_reverse = e_rrev_q;

endmodule

`default_nettype wire
